// ===== design/sps_pkg.sv =====
package sps_pkg;

    localparam int LEVELS_W = 3;

    localparam logic [1:0] CHILD_A   = 2'd0;
    localparam logic [1:0] CHILD_B   = 2'd1;
    localparam logic [1:0] CHILD_C   = 2'd2;
    localparam logic [1:0] CHILD_MID = 2'd3;

    typedef struct packed {
        logic valid;
        logic last;
    } sps_ctl_t;

endpackage

// ===== design/sps_split.sv =====
module sps_split import sps_pkg::*; #(
    parameter int CB = 16,
    parameter int PW = 6,
    parameter int DW = 2,
    parameter int D  = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sps_ctl_t             ctl_in,
    input  logic [PW-1:0]        path_in,
    input  logic [DW-1:0]        splits_in,
    input  logic [8:0][CB-1:0]   tri_in,
    output sps_ctl_t             ctl_out,
    output logic [PW-1:0]        path_out,
    output logic [DW-1:0]        splits_out,
    output logic [8:0][CB-1:0]   tri_out
);

    sps_ctl_t               ctl_reg;
    logic [PW-1:0]          path_reg;
    logic [DW-1:0]          splits_reg;
    logic [8:0][CB-1:0]     tri_reg;
    logic [8:0][CB-1:0]     tri_next;
    logic [2:0][CB-1:0]     va, vb, vc, mab, mbc, mca;
    logic [1:0]             digit;

    function automatic logic [CB-1:0] half_sum(input logic [CB-1:0] p, input logic [CB-1:0] q);
        logic signed [CB:0] s;
        s = $signed({p[CB-1], p}) + $signed({q[CB-1], q});
        return s[CB:1];
    endfunction

    always_comb
    begin
        va    = tri_in[2:0];
        vb    = tri_in[5:3];
        vc    = tri_in[8:6];
        digit = path_in[PW-1-2*D -: 2];
        for (int j = 0; j < 3; j++)
        begin
            mab[j] = half_sum(va[j], vb[j]);
            mbc[j] = half_sum(vb[j], vc[j]);
            mca[j] = half_sum(vc[j], va[j]);
        end
        tri_next = tri_in;
        if (splits_in > DW'(D))
        begin
            case (digit)
                CHILD_A:   tri_next = {mca, mab, va};
                CHILD_B:   tri_next = {mbc, vb, mab};
                CHILD_C:   tri_next = {vc, mbc, mca};
                CHILD_MID: tri_next = {mca, mbc, mab};
                default:   tri_next = tri_in;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        path_reg   <= path_in;
        splits_reg <= splits_in;
        tri_reg    <= tri_next;
    end

    assign ctl_out    = ctl_reg;
    assign path_out   = path_reg;
    assign splits_out = splits_reg;
    assign tri_out    = tri_reg;

endmodule

// ===== design/sps_norm.sv =====
module sps_norm import sps_pkg::*; #(
    parameter int CB = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sps_ctl_t             ctl_in,
    input  logic [8:0][CB-1:0]   tri_in,
    output sps_ctl_t             ctl_out,
    output logic [8:0][CB-1:0]   tri_out
);

    localparam int F   = CB - 2;
    localparam int NST = F + 1;
    localparam int SQW = 2 * CB - 1;
    localparam int SW  = 2 * CB;
    localparam int AW  = 4 * CB + 2;
    localparam int QW  = CB - 1;

    sps_ctl_t               ctl0_reg;
    sps_ctl_t               ctl_reg [0:NST];
    sps_ctl_t               ctl_out_reg;

    logic [SQW-1:0]         sq0_reg [0:8];
    logic [SQW-1:0]         sq0_next [0:8];
    logic [8:0]             neg0_reg, neg0_next;

    logic signed [AW-1:0]   a_reg [0:F][0:8];
    logic signed [AW-1:0]   a_next [0:F][0:8];
    logic signed [AW-1:0]   b_reg [0:F][0:8];
    logic signed [AW-1:0]   b_next [0:F][0:8];
    logic [QW-1:0]          q_reg [0:NST][0:8];
    logic [QW-1:0]          q_next [0:NST][0:8];
    logic [SQW-1:0]         x2_reg [0:NST][0:8];
    logic [SQW-1:0]         x2_next [0:NST][0:8];
    logic [SW-1:0]          s_reg [0:NST][0:2];
    logic [SW-1:0]          s_next [0:NST][0:2];
    logic [8:0]             neg_reg [0:NST];
    logic [8:0]             neg_next [0:NST];
    logic [2:0]             zero_reg [0:NST];
    logic [2:0]             zero_next [0:NST];

    logic [8:0][CB-1:0]     out_reg, out_next;

    always_comb
    begin
        logic [CB-1:0]          mag;
        logic [2*CB-1:0]        prod;
        logic [SW-1:0]          ssum;
        logic signed [AW-1:0]   sv, at, bt, xx;
        logic                   ok;
        logic [CB-1:0]          qe;

        for (int c = 0; c < 9; c++)
        begin
            mag          = tri_in[c][CB-1] ? (~tri_in[c] + CB'(1)) : tri_in[c];
            prod         = mag * mag;
            sq0_next[c]  = prod[SQW-1:0];
            neg0_next[c] = tri_in[c][CB-1];
        end

        for (int v = 0; v < 3; v++)
        begin
            ssum = SW'(sq0_reg[3*v]) + SW'(sq0_reg[3*v+1]) + SW'(sq0_reg[3*v+2]);
            s_next[0][v]    = ssum;
            zero_next[0][v] = (ssum == '0);
            for (int j = 0; j < 3; j++)
            begin
                a_next[0][3*v+j]  = $signed(AW'(ssum));
                b_next[0][3*v+j]  = -$signed(AW'(ssum));
                q_next[0][3*v+j]  = '0;
                x2_next[0][3*v+j] = sq0_reg[3*v+j];
            end
        end
        neg_next[0] = neg0_reg;

        // One quotient bit per stage: t = 2q-1, A = t*t*S, B = t*S kept by shifts and adds.
        for (int n = 0; n <= F; n++)
        begin
            for (int c = 0; c < 9; c++)
            begin
                sv = $signed(AW'(s_reg[n][c/3]));
                at = a_reg[n][c] + (b_reg[n][c] <<< (F - n + 2)) + (sv <<< (2*(F - n) + 2));
                bt = b_reg[n][c] + (sv <<< (F - n + 1));
                xx = $signed(AW'(x2_reg[n][c])) <<< (2*F + 2);
                ok = (at <= xx);
                q_next[n+1][c]  = ok ? (q_reg[n][c] | (QW'(1) << (F - n))) : q_reg[n][c];
                x2_next[n+1][c] = x2_reg[n][c];
                if (n < F)
                begin
                    a_next[n+1][c] = ok ? at : a_reg[n][c];
                    b_next[n+1][c] = ok ? bt : b_reg[n][c];
                end
            end
            for (int v = 0; v < 3; v++)
            begin
                s_next[n+1][v] = s_reg[n][v];
            end
            neg_next[n+1]  = neg_reg[n];
            zero_next[n+1] = zero_reg[n];
        end

        for (int c = 0; c < 9; c++)
        begin
            qe = CB'(q_reg[NST][c]);
            if (zero_reg[NST][c/3])
                out_next[c] = '0;
            else if (neg_reg[NST][c])
                out_next[c] = ~qe + CB'(1);
            else
                out_next[c] = qe;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg    <= '0;
            ctl_out_reg <= '0;
            for (int n = 0; n <= NST; n++)
            begin
                ctl_reg[n] <= '0;
            end
        end
        else
        begin
            ctl0_reg   <= ctl_in;
            ctl_reg[0] <= ctl0_reg;
            for (int n = 0; n < NST; n++)
            begin
                ctl_reg[n+1] <= ctl_reg[n];
            end
            ctl_out_reg <= ctl_reg[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        sq0_reg  <= sq0_next;
        neg0_reg <= neg0_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        q_reg    <= q_next;
        x2_reg   <= x2_next;
        s_reg    <= s_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        out_reg  <= out_next;
    end

    assign ctl_out = ctl_out_reg;
    assign tri_out = out_reg;

endmodule

// ===== design/triangle_sphere_subdivider.sv =====
// Sphere mesh refiner. A seed triangle is transferred at a rising edge where
// start is high and busy is low. The block then splits it levels-1 times (levels
// clamped to 1..MAX_LEVELS) and issues the 4^(levels-1) final triangles
// depth-first, one per cycle, with busy high while they issue; at default
// settings that is 64 triangles. The issue counter in the generator sets this rate.
// Each result is shown for one cycle with out_valid high; last_facet marks
// the final triangle of a seed. The receiver cannot stall, and the pipeline
// never stalls either: every triangle moves one stage per cycle.
// A result passes, after it is issued, through the split stages, a square
// stage, a sum stage, one stage per quotient bit and an output register.
// The levels register is written through cfg_we and cfg_wdata; the user must
// write it only while idle, which the block itself does not enforce.
// Reset clears all valid bits and sets levels to 4; no clearing pass is needed.
module triangle_sphere_subdivider import sps_pkg::*; #(
    parameter int MAX_LEVELS = 4,
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cfg_we,
    input  logic [LEVELS_W-1:0]          cfg_wdata,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] az,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by_coord,
    input  logic signed [COORD_BITS-1:0] bz,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic signed [COORD_BITS-1:0] cz,
    output logic                         out_valid,
    output logic signed [COORD_BITS-1:0] out_ax,
    output logic signed [COORD_BITS-1:0] out_ay,
    output logic signed [COORD_BITS-1:0] out_az,
    output logic signed [COORD_BITS-1:0] out_bx,
    output logic signed [COORD_BITS-1:0] out_by,
    output logic signed [COORD_BITS-1:0] out_bz,
    output logic signed [COORD_BITS-1:0] out_cx,
    output logic signed [COORD_BITS-1:0] out_cy,
    output logic signed [COORD_BITS-1:0] out_cz,
    output logic                         last_facet
);

    localparam int CB   = COORD_BITS;
    localparam int MAXS = MAX_LEVELS - 1;
    localparam int PW   = (MAXS > 0) ? 2 * MAXS : 1;
    localparam int DW   = (MAXS > 0) ? $clog2(MAXS + 1) : 1;

    logic [LEVELS_W-1:0]    levels_reg;
    logic                   busy_reg;
    logic [PW-1:0]          k_reg;
    logic [PW-1:0]          kmax_reg, kmax_next;
    logic [DW-1:0]          splits_reg, splits_next;
    logic [8:0][CB-1:0]     seed_reg;
    logic [LEVELS_W-1:0]    lv;
    logic [PW:0]            one_sh;

    sps_ctl_t               sp_ctl [0:MAXS];
    logic [PW-1:0]          sp_path [0:MAXS];
    logic [DW-1:0]          sp_splits [0:MAXS];
    logic [8:0][CB-1:0]     sp_tri [0:MAXS];

    sps_ctl_t               nm_ctl;
    logic [8:0][CB-1:0]     nm_tri;

    always_comb
    begin
        if (levels_reg == '0)
            lv = LEVELS_W'(1);
        else if (levels_reg > LEVELS_W'(MAX_LEVELS))
            lv = LEVELS_W'(MAX_LEVELS);
        else
            lv = levels_reg;
        splits_next = DW'(lv - LEVELS_W'(1));
        one_sh      = (PW+1)'(1) << {splits_next, 1'b0};
        kmax_next   = PW'(one_sh - (PW+1)'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= LEVELS_W'(4);
            busy_reg   <= 1'b0;
            k_reg      <= '0;
            kmax_reg   <= '0;
            splits_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                levels_reg <= cfg_wdata;
            end
            if (start && !busy_reg)
            begin
                busy_reg   <= 1'b1;
                k_reg      <= '0;
                kmax_reg   <= kmax_next;
                splits_reg <= splits_next;
            end
            else if (busy_reg)
            begin
                if (k_reg == kmax_reg)
                begin
                    busy_reg <= 1'b0;
                end
                k_reg <= k_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            seed_reg <= {cz, cy, cx, bz, by_coord, bx, az, ay, ax};
        end
    end

    assign sp_ctl[0].valid = busy_reg;
    assign sp_ctl[0].last  = (k_reg == kmax_reg);
    assign sp_path[0]      = PW'(k_reg << {DW'(MAXS) - splits_reg, 1'b0});
    assign sp_splits[0]    = splits_reg;
    assign sp_tri[0]       = seed_reg;

    for (genvar d = 0; d < MAXS; d++)
    begin : g_split
        sps_split #(
            .CB (CB),
            .PW (PW),
            .DW (DW),
            .D  (d)
        ) u_split (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl_in     (sp_ctl[d]),
            .path_in    (sp_path[d]),
            .splits_in  (sp_splits[d]),
            .tri_in     (sp_tri[d]),
            .ctl_out    (sp_ctl[d+1]),
            .path_out   (sp_path[d+1]),
            .splits_out (sp_splits[d+1]),
            .tri_out    (sp_tri[d+1])
        );
    end

    sps_norm #(
        .CB (CB)
    ) u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (sp_ctl[MAXS]),
        .tri_in  (sp_tri[MAXS]),
        .ctl_out (nm_ctl),
        .tri_out (nm_tri)
    );

    assign busy       = busy_reg;
    assign out_valid  = nm_ctl.valid;
    assign last_facet = nm_ctl.last;
    assign out_ax     = nm_tri[0];
    assign out_ay     = nm_tri[1];
    assign out_az     = nm_tri[2];
    assign out_bx     = nm_tri[3];
    assign out_by     = nm_tri[4];
    assign out_bz     = nm_tri[5];
    assign out_cx     = nm_tri[6];
    assign out_cy     = nm_tri[7];
    assign out_cz     = nm_tri[8];

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted seed did not raise busy.");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (k_reg == kmax_reg)) |=> !busy_reg)
        else $error("Generator kept running after its last triangle.");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (k_reg <= kmax_reg))
        else $error("Triangle index ran past the count for this seed.");

endmodule

// ===== dv/tb_triangle_sphere_subdivider.sv =====
module tb_triangle_sphere_subdivider import sps_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;
    localparam int FRAC = CW - 2;
    localparam int MAXLV = 4;
    localparam int SETTLE = 40;
    localparam longint LIMIT = 400000;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t c [9];
        logic   last;
    } facet_t;

    typedef struct {
        int lv;
        int v [9];
        bit chk;
        int e [9];
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic cfg_we = 1'b0;
    logic [LEVELS_W-1:0] cfg_wdata = '0;
    coord_t seed [9];
    logic out_valid;
    coord_t res [9];
    logic last_facet;

    facet_t facet_q [$];
    row_t rows [$];
    int errors = 0;
    longint cycles = 0;
    int cur_lv = 4;
    bit quiet = 1'b0;

    initial
    begin
        for (int i = 0; i < 9; i++)
        begin
            seed[i] = '0;
        end
    end

    always #5 clk = ~clk;

    triangle_sphere_subdivider u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .ax(seed[0]), .ay(seed[1]), .az(seed[2]),
        .bx(seed[3]), .by_coord(seed[4]), .bz(seed[5]),
        .cx(seed[6]), .cy(seed[7]), .cz(seed[8]),
        .out_valid(out_valid),
        .out_ax(res[0]), .out_ay(res[1]), .out_az(res[2]),
        .out_bx(res[3]), .out_by(res[4]), .out_bz(res[5]),
        .out_cx(res[6]), .out_cy(res[7]), .out_cz(res[8]),
        .last_facet(last_facet)
    );

    function automatic longint unit_comp(longint x, longint s);
        logic [127:0] rhs;
        logic [127:0] lhs;
        longint ax;
        longint lo;
        longint hi;
        longint mid;
        longint t;
        ax = (x < 0) ? -x : x;
        rhs = 128'(ax * ax) << (2 * FRAC + 2);
        lo = 0;
        hi = longint'(1) << FRAC;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            lhs = 128'(t * t) * 128'(s);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (x < 0) ? -lo : lo;
    endfunction

    task automatic predict_facets(input int lv_raw, input coord_t sd [9]);
        longint t [9];
        longint n [9];
        longint m [9];
        longint s;
        int lv;
        int splits;
        int count;
        int sel;
        facet_t f;
        lv = (lv_raw == 0) ? 1 : ((lv_raw > MAXLV) ? MAXLV : lv_raw);
        splits = lv - 1;
        count = 1 << (2 * splits);
        for (int k = 0; k < count; k++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                t[i] = sd[i];
            end
            for (int d = 0; d < splits; d++)
            begin
                sel = (k >> (2 * (splits - 1 - d))) & 3;
                // m holds mab, mbc, mca.
                for (int j = 0; j < 3; j++)
                begin
                    m[j] = (t[j] + t[3 + j]) >>> 1;
                    m[3 + j] = (t[3 + j] + t[6 + j]) >>> 1;
                    m[6 + j] = (t[6 + j] + t[j]) >>> 1;
                end
                for (int j = 0; j < 3; j++)
                begin
                    case (sel[1:0])
                        CHILD_A:
                        begin
                            t[3 + j] = m[j];
                            t[6 + j] = m[6 + j];
                        end
                        CHILD_B:
                        begin
                            t[j] = m[j];
                            t[6 + j] = m[3 + j];
                        end
                        CHILD_C:
                        begin
                            t[j] = m[6 + j];
                            t[3 + j] = m[3 + j];
                        end
                        default:
                        begin
                            t[j] = m[j];
                            t[3 + j] = m[3 + j];
                            t[6 + j] = m[6 + j];
                        end
                    endcase
                end
            end
            for (int v = 0; v < 3; v++)
            begin
                s = 0;
                for (int j = 0; j < 3; j++)
                begin
                    s += t[3 * v + j] * t[3 * v + j];
                end
                for (int j = 0; j < 3; j++)
                begin
                    n[3 * v + j] = (s == 0) ? 0 : unit_comp(t[3 * v + j], s);
                end
            end
            for (int i = 0; i < 9; i++)
            begin
                f.c[i] = coord_t'(n[i]);
            end
            f.last = (k + 1 == count);
            facet_q.push_back(f);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (facet_q.size() != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_levels(input int lv);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= LEVELS_W'(lv);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_lv = lv;
    endtask

    task automatic send_seed(input coord_t sd [9], input bit chk, input coord_t ex [9]);
        int gap;
        facet_t f;
        gap = (!quiet && $urandom_range(99) < 7) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        while (gap > 0)
        begin
            start <= 1'b0;
            gap--;
            @(negedge clk);
        end
        start <= 1'b1;
        for (int i = 0; i < 9; i++)
        begin
            seed[i] <= sd[i];
        end
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (chk)
        begin
            f.c = ex;
            f.last = 1'b1;
            facet_q.push_back(f);
        end
        else
        begin
            predict_facets(cur_lv, sd);
        end
    endtask

    always @(posedge clk)
    begin
        facet_t f;
        string names [10];
        names = '{"out_ax", "out_ay", "out_az", "out_bx", "out_by", "out_bz",
                  "out_cx", "out_cy", "out_cz", "last_facet"};
        if (rst_n && out_valid)
        begin
            if (facet_q.size() == 0)
            begin
                $error("result transfer with no expected facet");
                errors++;
            end
            else
            begin
                f = facet_q.pop_front();
                for (int i = 0; i < 9; i++)
                begin
                    if (res[i] !== f.c[i])
                    begin
                        $error("%s expected %0d actual %0d", names[i], f.c[i], res[i]);
                        errors++;
                    end
                end
                if (last_facet !== f.last)
                begin
                    $error("%s expected %0d actual %0d", names[9], f.last, last_facet);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("** triangle_sphere_subdivider: FAILED **");
            $finish;
        end
    end

    initial
    begin
        coord_t sd [9];
        coord_t ex [9];
        int lv;
        rows.push_back('{1, '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}, 1,
                         '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}});
        rows.push_back('{1, '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}, 1,
                         '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}});
        rows.push_back('{1, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 0}});
        rows.push_back('{1, '{-32768, 0, 0, 32767, 0, 0, 0, 100, 0}, 1,
                         '{-16384, 0, 0, 16384, 0, 0, 0, 16384, 0}});
        rows.push_back('{0, '{16384, 16384, 16384, -16384, -16384, 16384, -16384, 16384,
                              -16384}, 0, '{9{0}}});
        rows.push_back('{0, '{1, -2, 3, 1000, 0, -7, -5, 5, 5}, 0, '{9{0}}});
        rows.push_back('{7, '{16384, 16384, 16384, -16384, -16384, 16384, -16384, 16384,
                              -16384}, 0, '{9{0}}});
        rows.push_back('{7, '{16384, 16384, 16384, -16384, 16384, -16384, 16384, -16384,
                              -16384}, 0, '{9{0}}});
        rows.push_back('{7, '{16384, 16384, 16384, 16384, -16384, -16384, -16384, -16384,
                              16384}, 0, '{9{0}}});
        rows.push_back('{7, '{-16384, -16384, 16384, 16384, -16384, -16384, -16384, 16384,
                              -16384}, 0, '{9{0}}});
        rows.push_back('{2, '{-32768, -32768, -32768, 32767, 32767, 32767, -16384, 16384,
                              -16384}, 0, '{9{0}}});
        rows.push_back('{3, '{1, 0, 0, 0, -1, 0, -1, -1, -1}, 0, '{9{0}}});
        rows.push_back('{4, '{16384, -16384, 0, 0, 16384, 16384, -16384, 0, 16384}, 0,
                         '{9{0}}});
        rows.push_back('{5, '{0, 0, 0, 16384, 0, 0, 0, -16384, 0}, 0, '{9{0}}});
        rows.push_back('{1, '{-1, -1, -1, 32767, -32768, 1, 3, 4, 0}, 0, '{9{0}}});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[r])
        begin
            if (rows[r].lv != cur_lv)
            begin
                write_levels(rows[r].lv);
            end
            for (int i = 0; i < 9; i++)
            begin
                sd[i] = coord_t'(rows[r].v[i]);
                ex[i] = coord_t'(rows[r].e[i]);
            end
            send_seed(sd, rows[r].chk, ex);
        end

        for (int n = 0; n < 115; n++)
        begin
            if (n % 20 == 0)
            begin
                lv = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(0, 7);
                write_levels(lv);
            end
            quiet = (n >= 60 && n < 90);
            for (int i = 0; i < 9; i++)
            begin
                if ($urandom_range(99) < 80)
                    sd[i] = coord_t'($urandom_range(32768) - 16384);
                else
                    sd[i] = coord_t'($urandom);
            end
            send_seed(sd, 1'b0, ex);
        end

        wait_drained();
        if (errors == 0)
        begin
            $display("** triangle_sphere_subdivider: PASSED **");
        end
        else
        begin
            $display("** triangle_sphere_subdivider: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sps_pkg.sv
design/sps_split.sv
design/sps_norm.sv
design/triangle_sphere_subdivider.sv
dv/tb_triangle_sphere_subdivider.sv
